@@ rtl/invert_matrix_3x3_core_defines.svh @@
// Assertion macros used by invert_matrix_3x3_core; they expect clk and rst_n in scope.
`ifndef INVERT_MATRIX_3X3_CORE_DEFINES_SVH
`define INVERT_MATRIX_3X3_CORE_DEFINES_SVH

// same-cycle implication
`define IMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IMX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/imx_pkg.sv @@
package imx_pkg;

  localparam int IMX_FRAC_BITS = 16;
  localparam int IMX_WORD_BITS = 32;
  localparam int IO_W          = 32;
  localparam int DET_W         = 64;
  localparam int NUM_LANES     = 9;
  localparam int FRONT_LAT     = 6;

  typedef struct packed {
    logic [NUM_LANES-1:0][IO_W-1:0] inv;
    logic [DET_W-1:0]               det;
    logic                           sing;
  } imx_res_t;

endpackage

@@ rtl/invert_matrix_3x3_core.sv @@
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall  | in_a00 .. in_a22, Q16.16
// out_    | output    | out_valid / out_stall| out_inv00 .. out_inv22, out_determinant,
//         |           |                      | out_singular
//
// One matrix per cycle, sustained while in_stall is low. The nine divider lanes
// run side by side, one quotient bit per stage.
// rst_n is synchronous, active low; it clears the valid pipeline and the output and skid valid flags.
// A skid register behind the output register lets one more transaction in while
// the output is stalled; in_stall is high only while that skid is full.
`include "invert_matrix_3x3_core_defines.svh"

module invert_matrix_3x3_core import imx_pkg::*; #(
  parameter int FRAC_BITS = IMX_FRAC_BITS,
  parameter int WORD_BITS = IMX_WORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IO_W-1:0]  in_a00,
  input  logic signed [IO_W-1:0]  in_a01,
  input  logic signed [IO_W-1:0]  in_a02,
  input  logic signed [IO_W-1:0]  in_a10,
  input  logic signed [IO_W-1:0]  in_a11,
  input  logic signed [IO_W-1:0]  in_a12,
  input  logic signed [IO_W-1:0]  in_a20,
  input  logic signed [IO_W-1:0]  in_a21,
  input  logic signed [IO_W-1:0]  in_a22,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [IO_W-1:0]  out_inv00,
  output logic signed [IO_W-1:0]  out_inv01,
  output logic signed [IO_W-1:0]  out_inv02,
  output logic signed [IO_W-1:0]  out_inv10,
  output logic signed [IO_W-1:0]  out_inv11,
  output logic signed [IO_W-1:0]  out_inv12,
  output logic signed [IO_W-1:0]  out_inv20,
  output logic signed [IO_W-1:0]  out_inv21,
  output logic signed [IO_W-1:0]  out_inv22,
  output logic signed [DET_W-1:0] out_determinant,
  output logic                    out_singular
);

  localparam int W        = WORD_BITS;
  localparam int NUMW     = 2*W + 2*FRAC_BITS;
  localparam int DW       = 3*W;
  localparam int LANE_LAT = W + 4;
  localparam int LAT      = FRONT_LAT + LANE_LAT;
  localparam int SH       = 3*FRAC_BITS - 32;
  localparam int SHR      = (SH > 0) ? SH : 0;
  localparam int SHL      = (SH < 0) ? -SH : 0;
  localparam int XW       = (3*W+8 > DET_W+1) ? 3*W+8 : DET_W+1;

  logic                en;
  logic signed [W-1:0] elem [NUM_LANES];
  logic [NUMW-1:0]     num  [NUM_LANES];
  logic                neg  [NUM_LANES];
  logic [DW-1:0]       dmag;
  logic                dneg;
  logic                sing;
  logic signed [W-1:0] res  [NUM_LANES];

  logic [LAT-1:0]      vl_r;
  logic [DET_W-1:0]    sb_det_r  [LANE_LAT];
  logic                sb_sing_r [LANE_LAT];
  logic [XW-1:0]       dx;
  logic [DET_W-1:0]    dlim;
  logic [DET_W-1:0]    dv;
  logic [DET_W-1:0]    det0;

  imx_res_t            m_res;
  imx_res_t            out_r;
  imx_res_t            sk_r;
  logic                out_v_r, out_v_nxt;
  logic                sk_v_r, sk_v_nxt;
  logic                take, out_fire;
  logic                ld_pipe, ld_skid, ld_sk;

  assign en       = !sk_v_r;
  assign in_stall = sk_v_r;

  assign elem[0] = $signed(in_a00[W-1:0]);
  assign elem[1] = $signed(in_a01[W-1:0]);
  assign elem[2] = $signed(in_a02[W-1:0]);
  assign elem[3] = $signed(in_a10[W-1:0]);
  assign elem[4] = $signed(in_a11[W-1:0]);
  assign elem[5] = $signed(in_a12[W-1:0]);
  assign elem[6] = $signed(in_a20[W-1:0]);
  assign elem[7] = $signed(in_a21[W-1:0]);
  assign elem[8] = $signed(in_a22[W-1:0]);

  imx_det #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_det (
    .clk  (clk),
    .en   (en),
    .elem (elem),
    .num  (num),
    .neg  (neg),
    .dmag (dmag),
    .dneg (dneg),
    .sing (sing)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    imx_div_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_lane (
      .clk (clk),
      .en  (en),
      .num (num[l]),
      .den (dmag),
      .neg (neg[l]),
      .res (res[l])
    );
  end

  // determinant rescaled to 32 fraction bits, saturated to 64 bits
  assign dx   = (XW'(dmag) >> SHR) << SHL;
  assign dlim = dneg ? {1'b1, {(DET_W-1){1'b0}}} : {1'b0, {(DET_W-1){1'b1}}};
  assign dv   = (dx > XW'(dlim)) ? dlim : dx[DET_W-1:0];
  assign det0 = dneg ? -dv : dv;

  always_ff @(posedge clk) begin
    if (en) begin
      sb_det_r[0]  <= det0;
      sb_sing_r[0] <= sing;
      for (int i = 1; i < LANE_LAT; i++) begin
        sb_det_r[i]  <= sb_det_r[i-1];
        sb_sing_r[i] <= sb_sing_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else if (en) begin
      vl_r <= {vl_r[LAT-2:0], in_valid};
    end
  end

  // merge lanes; a singular matrix gives all-zero entries
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      m_res.inv[l] = sb_sing_r[LANE_LAT-1] ? '0 : IO_W'(res[l]);
    end
    m_res.det  = sb_det_r[LANE_LAT-1];
    m_res.sing = sb_sing_r[LANE_LAT-1];
  end

  assign take     = en && vl_r[LAT-1];
  assign out_fire = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    ld_pipe   = 1'b0;
    ld_skid   = 1'b0;
    ld_sk     = 1'b0;
    if (out_fire || !out_v_r) begin
      if (sk_v_r) begin
        ld_skid   = 1'b1;
        out_v_nxt = 1'b1;
        sk_v_nxt  = 1'b0;
      end else if (take) begin
        ld_pipe   = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (take) begin
      ld_sk    = 1'b1;
      sk_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_skid) begin
      out_r <= sk_r;
    end else if (ld_pipe) begin
      out_r <= m_res;
    end
    if (ld_sk) begin
      sk_r <= m_res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_inv00       = out_r.inv[0];
  assign out_inv01       = out_r.inv[1];
  assign out_inv02       = out_r.inv[2];
  assign out_inv10       = out_r.inv[3];
  assign out_inv11       = out_r.inv[4];
  assign out_inv12       = out_r.inv[5];
  assign out_inv20       = out_r.inv[6];
  assign out_inv21       = out_r.inv[7];
  assign out_inv22       = out_r.inv[8];
  assign out_determinant = out_r.det;
  assign out_singular    = out_r.sing;

  `IMX_ASSERT_IMP(a_skid_needs_out, sk_v_r, out_v_r, "skid full with output empty")
  `IMX_ASSERT_NXT(a_skid_holds, sk_v_r && out_stall, sk_v_r, "skid dropped a transaction")
  `IMX_ASSERT_NXT(a_no_drop, take && out_v_r && out_stall, sk_v_r, "transaction lost at output")
  `IMX_ASSERT_IMP(a_singular_zero, out_v_r && out_r.sing, out_r.det == '0 && out_r.inv == '0, "singular result not zero")

endmodule

@@ rtl/imx_det.sv @@
module imx_det import imx_pkg::*; #(
  parameter int FRAC_BITS = IMX_FRAC_BITS,
  parameter int WORD_BITS = IMX_WORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [WORD_BITS-1:0]          elem [NUM_LANES],
  output logic [2*WORD_BITS+2*FRAC_BITS-1:0]   num  [NUM_LANES],
  output logic                                 neg  [NUM_LANES],
  output logic [3*WORD_BITS-1:0]               dmag,
  output logic                                 dneg,
  output logic                                 sing
);

  localparam int W    = WORD_BITS;
  localparam int MW   = 2*W + 1;
  localparam int AW   = 3*W + 2;
  localparam int DW   = 3*W;
  localparam int NUMW = 2*W + 2*FRAC_BITS;

  logic signed [W-1:0]    e_r   [NUM_LANES];
  logic signed [2*W-1:0]  pa_r  [NUM_LANES];
  logic signed [2*W-1:0]  pb_r  [NUM_LANES];
  logic signed [W-1:0]    e0a_r [3];
  logic signed [W-1:0]    e0b_r [3];
  logic signed [MW-1:0]   mn_r  [NUM_LANES];
  logic signed [MW-1:0]   mnc_r [NUM_LANES];
  logic signed [MW-1:0]   mnd_r [NUM_LANES];
  logic [2*W-1:0]         pl_r  [3];
  logic [2*W-1:0]         ph_r  [3];
  logic                   tn_r  [3];
  logic signed [AW-1:0]   t     [3];
  logic signed [AW-1:0]   acc_r;
  logic [AW-1:0]          amag;
  logic [NUMW-1:0]        num_r [NUM_LANES];
  logic                   neg_r [NUM_LANES];
  logic [DW-1:0]          dmag_r;
  logic                   dneg_r;
  logic                   sing_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        e_r[k]   <= elem[k];
        mn_r[k]  <= MW'(pa_r[k]) - MW'(pb_r[k]);
        mnc_r[k] <= mn_r[k];
        mnd_r[k] <= mnc_r[k];
      end
      for (int k = 0; k < 3; k++) begin
        e0a_r[k] <= e_r[k];
        e0b_r[k] <= e0a_r[k];
      end
    end
  end

  // 2x2 minors, two products each
  for (genvar m = 0; m < NUM_LANES; m++) begin : g_minor
    localparam int I  = m / 3;
    localparam int J  = m % 3;
    localparam int R0 = (I == 0) ? 1 : 0;
    localparam int R1 = (I == 2) ? 1 : 2;
    localparam int C0 = (J == 0) ? 1 : 0;
    localparam int C1 = (J == 2) ? 1 : 2;
    always_ff @(posedge clk) begin
      if (en) begin
        pa_r[m] <= e_r[R0*3+C0] * e_r[R1*3+C1];
        pb_r[m] <= e_r[R0*3+C1] * e_r[R1*3+C0];
      end
    end
  end

  // row-0 expansion: magnitude products split in two halves
  for (genvar k = 0; k < 3; k++) begin : g_exp
    logic [W-1:0]   me;
    logic [2*W-1:0] mm;
    logic [DW-1:0]  p;
    assign me = e0b_r[k][W-1] ? W'(-e0b_r[k]) : W'(e0b_r[k]);
    assign mm = mn_r[k][MW-1] ? (2*W)'(-mn_r[k]) : (2*W)'(mn_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[k] <= me * mm[W-1:0];
        ph_r[k] <= me * mm[2*W-1:W];
        tn_r[k] <= e0b_r[k][W-1] ^ mn_r[k][MW-1] ^ (k == 1);
      end
    end
    assign p    = {ph_r[k], {W{1'b0}}} + DW'(pl_r[k]);
    assign t[k] = tn_r[k] ? -$signed(AW'(p)) : $signed(AW'(p));
  end

  assign amag = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= t[0] + t[1] + t[2];
      dneg_r <= acc_r[AW-1];
      dmag_r <= amag[DW-1:0];
      sing_r <= (acc_r == '0);
    end
  end

  // lane (r,c) divides the transposed cofactor of minor (c,r)
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam int R = l / 3;
    localparam int C = l % 3;
    localparam int M = C*3 + R;
    localparam logic ODD = ((R + C) % 2) == 1;
    logic [MW-1:0] cm;
    assign cm = mnd_r[M][MW-1] ? MW'(-mnd_r[M]) : MW'(mnd_r[M]);
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[l] <= {cm[2*W-1:0], {(2*FRAC_BITS){1'b0}}};
        neg_r[l] <= mnd_r[M][MW-1] ^ acc_r[AW-1] ^ ODD;
      end
    end
    assign num[l] = num_r[l];
    assign neg[l] = neg_r[l];
  end

  assign dmag = dmag_r;
  assign dneg = dneg_r;
  assign sing = sing_r;

endmodule

@@ rtl/imx_div_lane.sv @@
module imx_div_lane import imx_pkg::*; #(
  parameter int FRAC_BITS = IMX_FRAC_BITS,
  parameter int WORD_BITS = IMX_WORD_BITS
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [2*WORD_BITS+2*FRAC_BITS-1:0] num,
  input  logic [3*WORD_BITS-1:0]             den,
  input  logic                               neg,
  output logic signed [WORD_BITS-1:0]        res
);

  localparam int W    = WORD_BITS;
  localparam int NUMW = 2*W + 2*FRAC_BITS;
  localparam int DW   = 3*W;
  localparam int CW   = (NUMW > 4*W+1) ? NUMW : 4*W+1;
  localparam int QW   = W + 2;
  localparam int NST  = W + 2;

  logic [CW-1:0] rem_r [NST];
  logic [DW-1:0] den_r [NST];
  logic [QW-1:0] q_r   [NST+1];
  logic          neg_r [NST+1];
  logic [QW-1:0] lim;
  logic [QW-1:0] v;
  logic signed [W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar s = 1; s <= NST; s++) begin : g_step
    localparam int K = NST - s;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(den_r[s-1]) << K;
    assign ge  = rem_r[s-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]   <= q_r[s-1] | (QW'(ge) << K);
        neg_r[s] <= neg_r[s-1];
      end
    end
    if (s < NST) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? rem_r[s-1] - dsh : rem_r[s-1];
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  // top quotient bit set means well past either limit
  assign lim = neg_r[NST] ? (QW'(1) << (W-1)) : (QW'(1) << (W-1)) - QW'(1);
  assign v   = (q_r[NST] > lim) ? lim : q_r[NST];

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= neg_r[NST] ? W'(-v) : W'(v);
    end
  end

  assign res = res_r;

endmodule

@@ tb/sv/tb_invert_matrix_3x3_core.sv @@
`timescale 1ns / 100ps

module tb_invert_matrix_3x3_core;
  import imx_pkg::*;

  typedef struct {
    logic signed [IO_W-1:0] a [9];
  } matrix_t;

  typedef struct {
    logic [IO_W-1:0]  inv [9];
    logic [DET_W-1:0] det;
    logic             sing;
  } inverse_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [IO_W-1:0] in_a [9];
  logic signed [IO_W-1:0] out_inv [9];
  logic signed [DET_W-1:0] out_determinant;
  logic out_singular;

  matrix_t  pending_mats[$];
  inverse_t expected_inverses[$];
  int errors;
  int sender_idle_pct, receiver_idle_pct;
  bit hold_receiver, hold_sender;
  int hold_count;

  invert_matrix_3x3_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inv00(out_inv[0]), .out_inv01(out_inv[1]), .out_inv02(out_inv[2]),
    .out_inv10(out_inv[3]), .out_inv11(out_inv[4]), .out_inv12(out_inv[5]),
    .out_inv20(out_inv[6]), .out_inv21(out_inv[7]), .out_inv22(out_inv[8]),
    .out_determinant(out_determinant), .out_singular(out_singular)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // element as a sign-extended value of the low WORD_BITS bits
  function automatic logic signed [63:0] elem(logic [IO_W-1:0] v);
    logic signed [63:0] s;
    s = $signed({{(64-IO_W){1'b0}}, v}) <<< (64 - IMX_WORD_BITS);
    return s >>> (64 - IMX_WORD_BITS);
  endfunction

  function automatic inverse_t invert_matrix(matrix_t m);
    inverse_t r;
    logic signed [63:0] e [3][3];
    logic signed [127:0] mn [3][3];
    logic signed [255:0] det, num, q;
    logic signed [255:0] wlim_hi, wlim_lo, dlim_hi, dlim_lo, dq;
    int ra, rb, ca, cb;
    for (int k = 0; k < 9; k++) e[k/3][k%3] = elem(m.a[k]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        ra = (i == 0) ? 1 : 0; rb = (i == 2) ? 1 : 2;
        ca = (j == 0) ? 1 : 0; cb = (j == 2) ? 1 : 2;
        mn[i][j] = 128'(e[ra][ca]) * 128'(e[rb][cb]) - 128'(e[ra][cb]) * 128'(e[rb][ca]);
      end
    det = 256'(e[0][0]) * 256'(mn[0][0]) - 256'(e[0][1]) * 256'(mn[0][1])
        + 256'(e[0][2]) * 256'(mn[0][2]);
    if (det == 0) begin
      for (int k = 0; k < 9; k++) r.inv[k] = '0;
      r.det = '0;
      r.sing = 1'b1;
      return r;
    end
    wlim_hi = (256'sd1 <<< (IMX_WORD_BITS - 1)) - 1;
    wlim_lo = -(256'sd1 <<< (IMX_WORD_BITS - 1));
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++) begin
        num = 256'(mn[cc][rr]) <<< (2 * IMX_FRAC_BITS);
        if ((rr + cc) % 2) num = -num;
        q = num / det;  // truncates toward zero
        if (q > wlim_hi) q = wlim_hi;
        if (q < wlim_lo) q = wlim_lo;
        r.inv[rr*3+cc] = q[IO_W-1:0];
      end
    if (3 * IMX_FRAC_BITS >= 32) dq = det / (256'sd1 <<< (3 * IMX_FRAC_BITS - 32));
    else dq = det <<< (32 - 3 * IMX_FRAC_BITS);
    dlim_hi = (256'sd1 <<< 63) - 1;
    dlim_lo = -(256'sd1 <<< 63);
    if (dq > dlim_hi) dq = dlim_hi;
    if (dq < dlim_lo) dq = dlim_lo;
    r.det = dq[63:0];
    r.sing = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        matrix_t m;
        for (int k = 0; k < 9; k++) m.a[k] = in_a[k];
        expected_inverses.push_back(invert_matrix(m));
      end
      if (!in_valid || !in_stall) begin
        if (pending_mats.size() > 0 && !hold_sender &&
            $urandom_range(99) >= sender_idle_pct) begin
          matrix_t m;
          m = pending_mats.pop_front();
          for (int k = 0; k < 9; k++) in_a[k] <= m.a[k];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          report_mismatch("unexpected transaction", 64'd0, 64'd0);
        end else begin
          inverse_t x;
          x = expected_inverses.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_inv[k] !== x.inv[k])
              report_mismatch($sformatf("inv%0d%0d", k/3, k%3),
                              64'(out_inv[k]), 64'(x.inv[k]));
          if (out_determinant !== x.det)
            report_mismatch("determinant", out_determinant, x.det);
          if (out_singular !== x.sing)
            report_mismatch("singular", 64'(out_singular), 64'(x.sing));
        end
      end
      if (hold_receiver) begin
        out_stall <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  function automatic logic [IO_W-1:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(65536 * 4) - 65536 * 2;
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
      3: return $signed(16'($urandom)) <<< 8;
      default: return $signed(20'($urandom)) <<< $urandom_range(12);
    endcase
  endfunction

  task automatic add_mat(logic [IO_W-1:0] v0, v1, v2, v3, v4, v5, v6, v7, v8);
    matrix_t m;
    m.a[0] = v0; m.a[1] = v1; m.a[2] = v2; m.a[3] = v3; m.a[4] = v4;
    m.a[5] = v5; m.a[6] = v6; m.a[7] = v7; m.a[8] = v8;
    pending_mats.push_back(m);
  endtask

  task automatic add_random(int n);
    matrix_t m;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 9; k++) m.a[k] = rand_elem();
      // sometimes force a singular matrix by copying a row
      if ($urandom_range(9) == 0)
        for (int k = 0; k < 3; k++) m.a[3 + k] = m.a[k];
      pending_mats.push_back(m);
    end
  endtask

  task automatic drain();
    while (pending_mats.size() > 0 || in_valid || expected_inverses.size() > 0)
      @(posedge clk);
  endtask

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  initial begin
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    hold_receiver = 0;
    hold_sender = 0;
    for (int k = 0; k < 9; k++) in_a[k] = '0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    add_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
    add_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_mat(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
    add_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
    add_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
    add_mat(MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MINV, MAXV);
    add_mat(MINV, MINV, MINV, MINV, MAXV, MAXV, MINV, MAXV, MINV);
    add_mat(1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_mat(1, 0, 0, 0, 1, 0, 0, 0, 2);
    add_mat(32'hffff_ffff, 0, 0, 0, 1, 0, 0, 0, 1);
    add_mat(2*ONE, 0, 0, 0, -2*ONE, 0, 0, 0, 4*ONE);
    add_mat(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 10*ONE);
    add_mat(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE);
    add_mat(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);
    add_mat(0, 0, ONE, 0, ONE, 0, ONE, 0, 0);
    add_mat(MAXV, MAXV, 0, 0, MAXV, MAXV, MAXV, 0, MAXV);
    add_mat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'haaaa_aaaa,
            32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
    drain();

    sender_idle_pct = 30; receiver_idle_pct = 70;
    add_random(350);
    drain();

    // long receiver hold while the sender keeps offering
    hold_receiver = 1;
    add_random(100);
    while (hold_count < 300) @(posedge clk);
    hold_receiver = 0;
    drain();

    sender_idle_pct = 70; receiver_idle_pct = 30;
    add_random(300);
    drain();

    sender_idle_pct = 0; receiver_idle_pct = 0;
    add_random(300);
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/imx_pkg.sv
rtl/imx_det.sv
rtl/imx_div_lane.sv
rtl/invert_matrix_3x3_core.sv
tb/sv/tb_invert_matrix_3x3_core.sv
